[rtl/core/xo256p_pkg.sv]
// ----------------------------------------------------------------------------
// xo256p_pkg
// Shared types and constants for the xoshiro256+ generator: seed, jump
// polynomial, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package xo256p_pkg;

    localparam int WordWidth     = 64;
    localparam int NumWords      = 4;
    localparam int FractionWidth = 23;
    localparam int CountWidth    = 7;
    localparam int PolyBits      = WordWidth * NumWords;
    localparam int PolyIdxWidth  = $clog2(PolyBits);
    localparam int ShiftAmount   = 17;
    localparam int RotAmount     = 45;

    typedef logic [WordWidth-1:0] word_t;
    typedef word_t [NumWords-1:0] words_t;

    // operation codes carried on s_tuser
    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_JUMP     = 1'b1
    } op_t;

    localparam words_t SeedWords = {
        64'hea9bfe26838f091d, 64'h0c60dc05b8f9266a,
        64'h8f51e36d13fa4f21, 64'h172373c35cc277fb
    };

    // word 0 in the lowest bits, so bit index = word * 64 + bit
    localparam logic [PolyBits-1:0] JumpPoly = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_JUMP
    } ctrl_state_t;

    typedef struct packed {
        logic gen;       // advance once and capture a fraction
        logic step;      // one jump step: accumulate and advance
        logic poly_bit;  // jump polynomial bit for this step
        logic finish;    // last step of a jump: state takes the accumulators
    } dp_cmd_t;

endpackage

[rtl/core/xo256p_datapath.sv]
// ----------------------------------------------------------------------------
// xo256p_datapath
// State words, jump accumulators, the xoshiro256+ step and the fraction
// output register.
// ----------------------------------------------------------------------------
module xo256p_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  xo256p_pkg::dp_cmd_t                   cmd,
    output logic [xo256p_pkg::FractionWidth-1:0]  fraction
);
    import xo256p_pkg::*;

    words_t state_reg, state_next;
    words_t acc_reg, acc_next;
    words_t adv;
    words_t acc_upd;
    word_t  sum;
    logic [FractionWidth-1:0] frac_reg, frac_next;

    always_comb begin
        word_t t;
        word_t n0;
        word_t n1;
        word_t n2;
        word_t n3;
        t  = state_reg[1] << ShiftAmount;
        n2 = state_reg[2] ^ state_reg[0];
        n3 = state_reg[3] ^ state_reg[1];
        n1 = state_reg[1] ^ n2;
        n0 = state_reg[0] ^ n3;
        n2 = n2 ^ t;
        n3 = (n3 << RotAmount) | (n3 >> (WordWidth - RotAmount));
        adv = {n3, n2, n1, n0};
    end

    assign sum     = adv[0] + adv[3];
    assign acc_upd = cmd.poly_bit ? (acc_reg ^ state_reg) : acc_reg;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        if (cmd.gen) begin
            state_next = adv;
            frac_next  = sum[WordWidth-1 -: FractionWidth];
        end else if (cmd.step) begin
            if (cmd.finish) begin
                state_next = acc_upd;
                acc_next   = '0;
            end else begin
                state_next = adv;
                acc_next   = acc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SeedWords;
            acc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        frac_reg <= frac_next;
    end

    assign fraction = frac_reg;

endmodule

[rtl/core/xo256p_ctrl.sv]
// ----------------------------------------------------------------------------
// xo256p_ctrl
// Controller: input and output handshakes, jump count reduction and the
// 256-step sequencing of each jump.
// ----------------------------------------------------------------------------
module xo256p_ctrl #(
    parameter int JUMP_LIMIT = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                op,
    input  logic [xo256p_pkg::CountWidth-1:0]   jump_count,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output xo256p_pkg::dp_cmd_t                 cmd
);
    import xo256p_pkg::*;

    localparam logic [CountWidth:0] LimitW = (CountWidth + 1)'(JUMP_LIMIT);

    ctrl_state_t state_reg, state_next;
    logic [CountWidth-1:0]   jumps_reg, jumps_next;
    logic [PolyIdxWidth-1:0] bit_reg, bit_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    s_fire;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        jumps_next     = jumps_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (op_t'(op) == OP_GENERATE) begin
                        cmd.gen        = 1'b1;
                        out_valid_next = 1'b1;
                    end else begin
                        jumps_next = jumps_reg;
                        jumps_next = jump_count;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                // count modulo the limit by repeated subtraction
                if ({1'b0, jumps_reg} >= LimitW) begin
                    jumps_next = CountWidth'({1'b0, jumps_reg} - LimitW);
                end else if (jumps_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    bit_next   = '0;
                    state_next = ST_JUMP;
                end
            end
            ST_JUMP: begin
                cmd.step     = 1'b1;
                cmd.poly_bit = JumpPoly[bit_reg];
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == PolyIdxWidth'(PolyBits - 1)) begin
                    cmd.finish = 1'b1;
                    jumps_next = jumps_reg - 1'b1;
                    if (jumps_reg == CountWidth'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            jumps_reg     <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            jumps_reg     <= jumps_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/xoshiro256_plus_generator.sv]
// ----------------------------------------------------------------------------
// xoshiro256_plus_generator
// xoshiro256+ generator with a fixed seed, 23-bit fraction output and
// repeated 2^128-step jumps.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: s_tuser selects the operation (0 generate, 1 jump),
//   s_tdata[6:0] holds the jump count, used by jump only.
//   m_ channel: m_tdata[22:0] is the fraction, value = fraction * 2^-23.
//   a generate transaction advances the state once and its fraction appears
//   on m_ in the cycle after acceptance; with the sink ready, generate
//   transactions are taken every cycle.
//   a jump transaction returns nothing; it first reduces the count modulo
//   JUMP_LIMIT by repeated subtraction, then runs as many jumps as the
//   remainder, each over all jump polynomial bits (one polynomial bit per
//   cycle through the shared state update); s_tready stays low meanwhile.
//   reset loads the seed words and clears m_tvalid; the fraction register is not reset.
//   while m_tready is low, a waiting fraction holds and no new transaction
//   is taken; one is taken in the same cycle the waiting fraction leaves.
// ----------------------------------------------------------------------------
module xoshiro256_plus_generator #(
    parameter int JUMP_LIMIT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] jump_count, [7] zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [22:0] fraction, [23] zero
);
    import xo256p_pkg::*;

    dp_cmd_t                  cmd;
    logic [FractionWidth-1:0] fraction;

    xo256p_ctrl #(
        .JUMP_LIMIT(JUMP_LIMIT)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .op         (s_tuser),
        .jump_count (s_tdata[CountWidth-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd)
    );

    xo256p_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .fraction (fraction)
    );

    assign m_tdata = {1'b0, fraction};

endmodule

[rtl/core/xo256p_checker.sv]
// ----------------------------------------------------------------------------
// xo256p_checker
// Port-level checks for the xoshiro256+ generator, bound to the top level.
// ----------------------------------------------------------------------------
module xo256p_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import xo256p_pkg::*;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // a generate transaction yields a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op_t'(s_tuser) == OP_GENERATE) |=> m_tvalid)
        else $error("generate gave no result");

    // a jump transaction yields no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op_t'(s_tuser) == OP_JUMP) && !m_tvalid |=> !m_tvalid)
        else $error("jump produced a result");

    // input is blocked while jump work is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op_t'(s_tuser) == OP_JUMP) |=> !s_tready)
        else $error("input taken during jump");

endmodule

bind xoshiro256_plus_generator xo256p_checker u_checker (.*);
